// ===== hw/rtl/voxel_grid_ray_march_defines.svh =====
// ----------------------------------------------------------------------------
// Voxel grid ray march assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_RAY_MARCH_DEFINES_SVH
`define VOXEL_GRID_RAY_MARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VGRM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voxel grid ray march: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VGRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voxel grid ray march: next-cycle check failed");

`endif

// ===== hw/rtl/vgrm_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel grid ray march package
// Types, field widths and codes shared by the ray march block and its checker.
// ----------------------------------------------------------------------------
package vgrm_pkg;

    // Q.8 position width: origin and grid center fit; a long march can overflow it.
    localparam int POS_W    = 18;
    // Width of the integer part of a non-negative position.
    localparam int CIDX_W   = POS_W - 9;
    localparam int IN_W     = 80;
    localparam int OUT_W    = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE_STEP = 1'd1;

    localparam logic [7:0]  MAX_DEPTH_RESET  = 8'd1;
    localparam logic [16:0] SHADE_STEP_RESET = 17'd76800;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARCH,
        ST_SHADE,
        ST_LOSS,
        ST_RESULT
    } vgrm_state_t;

endpackage

// ===== hw/rtl/voxel_grid_ray_march.sv =====
// ----------------------------------------------------------------------------
// Voxel grid ray march
// Cubic voxel store with voxel writes and fixed-step ray scans.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_axis channel; s_axis_tuser selects a voxel write or a
// ray scan. Every item produces exactly one result transaction on m_axis.
// Registers max_depth and shade_step are written through the cfg channel,
// which is always ready; write them only while the block is idle.
// On a write the cell is written in the accept cycle and, if the output
// register is free, the result is loaded into it at the same edge.
// A scan steps through ST_MARCH, then on a hit through ST_SHADE and ST_LOSS,
// and ends in ST_RESULT, which raises m_axis_tvalid once the output register
// is free. The march loop reads one cell per cycle from the single-port voxel
// memory; a shade multiply and a clamp stage follow a hit.
// After reset the block clears all 2**(3*clog2(GRID_SIZE)) cells of the voxel
// memory (262144 at the default size), one cell per cycle; s_axis_tready
// stays low during that pass while configuration writes are still taken.
// The output register holds a result while m_axis_tready is low. A new item
// may still be accepted then; its result waits until the register frees up.
// ----------------------------------------------------------------------------
module voxel_grid_ray_march #(
    parameter int GRID_SIZE = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input item stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata from bit 0: pos_x[14], pos_y[14], pos_z[14], dir_x[10],
    // dir_y[10], dir_z[10], color[8].
    input  logic [vgrm_pkg::IN_W-1:0]         s_axis_tdata,
    // tuser from bit 0: op[1].
    input  logic                              s_axis_tuser,
    // Result stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata from bit 0: hit[1], shade[8], hit_depth[8], accepted[1], zeros[6].
    output logic [vgrm_pkg::OUT_W-1:0]        m_axis_tdata,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vgrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vgrm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import vgrm_pkg::*;

    // Each axis coordinate addresses CW bits; the memory is the cube of that.
    localparam int CW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
    localparam int AW = 3 * CW;
    localparam logic signed [POS_W-1:0] CENTER_Q8 = POS_W'(GRID_SIZE * 128);

    // True when a Q.8 grid coordinate falls in a cell inside the grid.
    function automatic logic in_grid(input logic signed [POS_W-1:0] q);
        return !q[POS_W-1] && (q[POS_W-2:8] < CIDX_W'(GRID_SIZE));
    endfunction

    function automatic logic [AW-1:0] cell_addr(
        input logic signed [POS_W-1:0] qx,
        input logic signed [POS_W-1:0] qy,
        input logic signed [POS_W-1:0] qz
    );
        return {qx[8 +: CW], qy[8 +: CW], qz[8 +: CW]};
    endfunction

    // Voxel memory: bit 8 is the valid bit, bits 7:0 the color.
    logic [8:0]    voxel_mem [2**AW];
    logic [8:0]    mem_rdata_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [8:0]    mem_wdata;

    vgrm_state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [7:0]    max_depth_reg, max_depth_next;
    logic [16:0]   shade_step_reg, shade_step_next;

    logic signed [POS_W-1:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic signed [9:0]       dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;

    logic [7:0]  issue_depth_reg, issue_depth_next;
    logic        issue_done_reg, issue_done_next;
    logic        rd_pend_reg, rd_pend_next;
    logic        rd_inside_reg, rd_inside_next;
    logic [7:0]  rd_depth_reg, rd_depth_next;
    logic [7:0]  color_reg, color_next;
    logic [24:0] prod_reg, prod_next;

    logic        res_hit_reg, res_hit_next;
    logic [7:0]  res_shade_reg, res_shade_next;
    logic [7:0]  res_depth_reg, res_depth_next;
    logic        res_acc_reg, res_acc_next;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    // Input positions moved to grid coordinates.
    logic signed [POS_W-1:0] in_px, in_py, in_pz;
    logic        in_accept;
    logic        out_free;
    logic        in_inside;
    logic        hit_now;
    logic        last_now;
    logic [16:0] loss;

    assign in_px = POS_W'($signed(s_axis_tdata[13:0])) + CENTER_Q8;
    assign in_py = POS_W'($signed(s_axis_tdata[27:14])) + CENTER_Q8;
    assign in_pz = POS_W'($signed(s_axis_tdata[41:28])) + CENTER_Q8;
    assign in_inside = in_grid(in_px) && in_grid(in_py) && in_grid(in_pz);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The result of the read issued in the previous cycle is tested here.
    assign hit_now  = rd_pend_reg && rd_inside_reg && mem_rdata_reg[8];
    assign last_now = rd_pend_reg && (rd_depth_reg == max_depth_reg);
    assign loss     = prod_reg[24:8];

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        max_depth_next   = max_depth_reg;
        shade_step_next  = shade_step_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        pz_next          = pz_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        dz_next          = dz_reg;
        issue_depth_next = issue_depth_reg;
        issue_done_next  = issue_done_reg;
        rd_pend_next     = 1'b0;
        rd_inside_next   = rd_inside_reg;
        rd_depth_next    = rd_depth_reg;
        color_next       = color_reg;
        prod_next        = prod_reg;
        res_hit_next     = res_hit_reg;
        res_shade_next   = res_shade_reg;
        res_depth_next   = res_depth_reg;
        res_acc_next     = res_acc_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_addr         = cell_addr(px_reg, py_reg, pz_reg);
        mem_wdata        = {1'b1, s_axis_tdata[79:72]};

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAX_DEPTH:  max_depth_next  = cfg_data[7:0];
                REG_SHADE_STEP: shade_step_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_accept && (s_axis_tuser == OP_WRITE))
                begin
                    // Cells outside the grid are left untouched.
                    mem_we       = in_inside;
                    mem_addr     = cell_addr(in_px, in_py, in_pz);
                    res_hit_next   = 1'b0;
                    res_shade_next = '0;
                    res_depth_next = '0;
                    res_acc_next   = in_inside;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {{(OUT_W-18){1'b0}}, in_inside, 8'd0, 8'd0, 1'b0};
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
                else if (in_accept)
                begin
                    px_next          = in_px;
                    py_next          = in_py;
                    pz_next          = in_pz;
                    dx_next          = $signed(s_axis_tdata[51:42]);
                    dy_next          = $signed(s_axis_tdata[61:52]);
                    dz_next          = $signed(s_axis_tdata[71:62]);
                    issue_depth_next = '0;
                    issue_done_next  = 1'b0;
                    state_next       = ST_MARCH;
                end
            end

            ST_MARCH:
            begin
                if (hit_now)
                begin
                    color_next     = mem_rdata_reg[7:0];
                    res_depth_next = rd_depth_reg;
                    state_next     = ST_SHADE;
                end
                else if (last_now)
                begin
                    res_hit_next   = 1'b0;
                    res_shade_next = '0;
                    res_depth_next = max_depth_reg;
                    res_acc_next   = 1'b0;
                    state_next     = ST_RESULT;
                end
                else if (!issue_done_reg)
                begin
                    // Read the next cell while the previous one is tested.
                    mem_re           = 1'b1;
                    rd_pend_next     = 1'b1;
                    rd_inside_next   = in_grid(px_reg) && in_grid(py_reg) && in_grid(pz_reg);
                    rd_depth_next    = issue_depth_reg;
                    px_next          = px_reg + POS_W'(dx_reg);
                    py_next          = py_reg + POS_W'(dy_reg);
                    pz_next          = pz_reg + POS_W'(dz_reg);
                    issue_depth_next = issue_depth_reg + 8'd1;
                    issue_done_next  = (issue_depth_reg == max_depth_reg);
                end
            end

            ST_SHADE:
            begin
                prod_next  = 25'(res_depth_reg) * 25'(shade_step_reg);
                state_next = ST_LOSS;
            end

            ST_LOSS:
            begin
                res_hit_next = 1'b1;
                res_acc_next = 1'b0;
                if (loss >= 17'(color_reg))
                begin
                    res_shade_next = '0;
                end
                else
                begin
                    res_shade_next = color_reg - loss[7:0];
                end
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(OUT_W-18){1'b0}}, res_acc_reg, res_depth_reg,
                                      res_shade_reg, res_hit_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Single-port voxel memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            voxel_mem[mem_addr] <= mem_wdata;
        end
        else if (mem_re)
        begin
            mem_rdata_reg <= voxel_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            max_depth_reg   <= MAX_DEPTH_RESET;
            shade_step_reg  <= SHADE_STEP_RESET;
            issue_done_reg  <= 1'b0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            max_depth_reg   <= max_depth_next;
            shade_step_reg  <= shade_step_next;
            issue_done_reg  <= issue_done_next;
            rd_pend_reg     <= rd_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg          <= px_next;
        py_reg          <= py_next;
        pz_reg          <= pz_next;
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        dz_reg          <= dz_next;
        issue_depth_reg <= issue_depth_next;
        rd_inside_reg   <= rd_inside_next;
        rd_depth_reg    <= rd_depth_next;
        color_reg       <= color_next;
        prod_reg        <= prod_next;
        res_hit_reg     <= res_hit_next;
        res_shade_reg   <= res_shade_next;
        res_depth_reg   <= res_depth_next;
        res_acc_reg     <= res_acc_next;
        out_data_reg    <= out_data_next;
    end

endmodule

// ===== hw/rtl/vgrm_checker.sv =====
// ----------------------------------------------------------------------------
// Voxel grid ray march checker
// Port-level assertions on the item and result channels, bound to the block.
// ----------------------------------------------------------------------------
`include "voxel_grid_ray_march_defines.svh"

module vgrm_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic s_axis_tuser,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);
    import vgrm_pkg::*;

    logic write_in;
    logic scan_in;

    assign write_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_WRITE);
    assign scan_in  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SCAN);

    // A stalled result stays offered.
    `VGRM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // A scan occupies the block, so no item is taken in the next cycle.
    `VGRM_ASSERT_NEXT(a_scan_busy, clk, rst_n, scan_in, !s_axis_tready)

    // A write with a free output register shows its result in the next cycle.
    `VGRM_ASSERT_NEXT(a_write_result, clk, rst_n,
        write_in && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid)

endmodule

bind voxel_grid_ray_march vgrm_checker u_vgrm_checker (.*);

// ===== tb/voxel_grid_ray_march_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel grid ray march testbench
// Streams voxel writes and ray scans into the block under several register
// settings and checks every result against a cycle-free model of the grid.
// ----------------------------------------------------------------------------
module voxel_grid_ray_march_test;

    import vgrm_pkg::*;

    localparam int GRID_SIZE  = 64;
    localparam int CENTER_Q8  = GRID_SIZE * 128;
    localparam int SLOT_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int POS_MIN    = -8192;
    localparam int POS_MAX    = 8191;
    // Length of the one long receiver hold-off, in cycles.
    localparam int LONG_HOLD  = 600;
    // Drain margin at the end.
    localparam int DRAIN_CYCLES = 300;

    // Input fields in tdata order: the last member sits in the lowest bits.
    typedef struct packed {
        logic [7:0]         color;
        logic signed [9:0]  dir_z, dir_y, dir_x;
        logic signed [13:0] pos_z, pos_y, pos_x;
    } ray_fields_t;

    typedef struct packed {
        logic        op;
        ray_fields_t f;
    } grid_item_t;

    // Result fields in tdata order, padding on top.
    typedef struct packed {
        logic [5:0] pad;
        logic       accepted;
        logic [7:0] hit_depth;
        logic [7:0] shade;
        logic       hit;
    } ray_outcome_t;

    typedef struct {
        int x;
        int y;
        int z;
    } voxel_spot_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    voxel_grid_ray_march #(
        .GRID_SIZE(GRID_SIZE)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Model of the grid and its registers, updated on accepted transactions.
    bit [8:0]      voxel_model [0:SLOT_COUNT-1];
    logic [7:0]    model_depth = MAX_DEPTH_RESET;
    logic [16:0]   model_step  = SHADE_STEP_RESET;

    grid_item_t    queued_items [$];
    ray_outcome_t  predicted_outcomes [$];
    voxel_spot_t   placed_spots [$];

    logic          s_fire = 1'b0;
    int            fail_count = 0;
    int            write_count = 0;
    int            scan_count = 0;
    int            hit_count = 0;
    int            miss_count = 0;
    int            setting_count = 0;
    int            hold_requests = 0;

    // Maps a Q.8 grid position to a store address; returns 0 outside the grid.
    function automatic bit locate_slot(input int qx, input int qy, input int qz,
                                       output int unsigned addr);
        addr = 0;
        if (qx < 0 || qy < 0 || qz < 0)
            return 1'b0;
        if ((qx >>> 8) >= GRID_SIZE || (qy >>> 8) >= GRID_SIZE || (qz >>> 8) >= GRID_SIZE)
            return 1'b0;
        addr = ((qx >>> 8) * GRID_SIZE + (qy >>> 8)) * GRID_SIZE + (qz >>> 8);
        return 1'b1;
    endfunction

    // Applies one item to the grid model and returns the result it causes.
    function automatic ray_outcome_t trace_item(input grid_item_t it);
        ray_outcome_t r;
        int           qx, qy, qz;
        int unsigned  addr;
        int unsigned  depth_no;
        longint unsigned loss;
        bit           done;
        r  = '0;
        qx = int'($signed(it.f.pos_x)) + CENTER_Q8;
        qy = int'($signed(it.f.pos_y)) + CENTER_Q8;
        qz = int'($signed(it.f.pos_z)) + CENTER_Q8;
        if (it.op == OP_WRITE)
        begin
            if (locate_slot(qx, qy, qz, addr))
            begin
                voxel_model[addr] = {1'b1, it.f.color};
                r.accepted = 1'b1;
            end
            return r;
        end
        depth_no = 0;
        done = 1'b0;
        while (!done)
        begin
            if (locate_slot(qx, qy, qz, addr) && voxel_model[addr][8])
            begin
                loss = (longint'(depth_no) * longint'(model_step)) >> 8;
                r.hit = 1'b1;
                r.shade = (loss >= voxel_model[addr][7:0]) ? 8'd0
                                                          : 8'(voxel_model[addr][7:0] - loss);
                r.hit_depth = depth_no[7:0];
                done = 1'b1;
            end
            else if (depth_no == model_depth)
            begin
                r.hit_depth = model_depth;
                done = 1'b1;
            end
            else
            begin
                qx += int'($signed(it.f.dir_x));
                qy += int'($signed(it.f.dir_y));
                qz += int'($signed(it.f.dir_z));
                depth_no++;
            end
        end
        return r;
    endfunction

    // Monitor: tracks register writes, checks results, predicts accepted items.
    always @(posedge clk)
    begin
        ray_outcome_t got;
        ray_outcome_t want;
        grid_item_t   taken;
        if (!rst_n)
            s_fire <= 1'b0;
        else
        begin
            s_fire <= s_axis_tvalid && s_axis_tready;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAX_DEPTH)
                    model_depth = cfg_data[7:0];
                else
                    model_step = cfg_data[16:0];
            end
            // Results are compared before the new item is predicted: a result
            // can never leave in the same cycle its item is taken.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (predicted_outcomes.size() == 0)
                begin
                    $error("result transaction with nothing outstanding: data %h",
                           m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = predicted_outcomes.pop_front();
                    if (got.hit !== want.hit)
                    begin
                        $error("hit mismatch: expected %0d, got %0d", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.shade !== want.shade)
                    begin
                        $error("shade mismatch: expected %0d, got %0d", want.shade, got.shade);
                        fail_count++;
                    end
                    if (got.hit_depth !== want.hit_depth)
                    begin
                        $error("hit_depth mismatch: expected %0d, got %0d",
                               want.hit_depth, got.hit_depth);
                        fail_count++;
                    end
                    if (got.accepted !== want.accepted)
                    begin
                        $error("accepted mismatch: expected %0d, got %0d",
                               want.accepted, got.accepted);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken.op = s_axis_tuser;
                taken.f = s_axis_tdata;
                want = trace_item(taken);
                predicted_outcomes.push_back(want);
                if (taken.op == OP_WRITE)
                    write_count++;
                else
                begin
                    scan_count++;
                    if (want.hit)
                        hit_count++;
                    else
                        miss_count++;
                end
            end
        end
    end

    // Driver: offers queued items in bursts separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        grid_item_t cur;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (queued_items.size() != 0)
            begin
                cur = queued_items.pop_front();
                s_axis_tdata  <= cur.f;
                s_axis_tuser  <= cur.op;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: changes between always ready, coin toss and mostly stalled,
    // and serves a long hold-off whenever one is requested.
    int hold_served = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    stall_left = $urandom_range(4, 60);
                end
                else
                    stall_left--;
                case (stall_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Blocks until every item is taken and every predicted result has left.
    // The check runs just after a rising edge, when the driver's outputs from
    // the last falling edge and the monitor's bookkeeping have both settled.
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (queued_items.size() != 0 || s_axis_tvalid || predicted_outcomes.size() != 0);
    endtask

    task automatic add_item(input logic op, input int px, input int py, input int pz,
                            input int dx, input int dy, input int dz, input int color);
        grid_item_t it;
        it.op = op;
        it.f.pos_x = px[13:0];
        it.f.pos_y = py[13:0];
        it.f.pos_z = pz[13:0];
        it.f.dir_x = dx[9:0];
        it.f.dir_y = dy[9:0];
        it.f.dir_z = dz[9:0];
        it.f.color = color[7:0];
        queued_items.push_back(it);
    endtask

    function automatic int rand_pos();
        return int'($urandom_range(0, 16383)) - 8192;
    endfunction

    function automatic int rand_dir();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return 0;
        if (pick == 1)
            return 256;
        if (pick == 2)
            return -256;
        return int'($urandom_range(0, 512)) - 256;
    endfunction

    function automatic int clamp_pos(input int v);
        return (v < POS_MIN) ? POS_MIN : ((v > POS_MAX) ? POS_MAX : v);
    endfunction

    function automatic bit pos_ok(input int v);
        return v >= POS_MIN && v <= POS_MAX;
    endfunction

    // Most scans are aimed at a voxel placed earlier so that they march for
    // a while and then hit; the rest are writes and unaimed scans.
    task automatic push_random_item(input int depth_cfg);
        int          pick, k, ox, oy, oz, dx, dy, dz;
        voxel_spot_t spot;
        pick = $urandom_range(0, 99);
        dx = rand_dir();
        dy = rand_dir();
        dz = rand_dir();
        if (pick < 30)
        begin
            if (placed_spots.size() != 0 && $urandom_range(0, 1) == 1)
            begin
                spot = placed_spots[$urandom_range(0, placed_spots.size() - 1)];
                spot.x = clamp_pos(spot.x + int'($urandom_range(0, 1536)) - 768);
                spot.y = clamp_pos(spot.y + int'($urandom_range(0, 1536)) - 768);
                spot.z = clamp_pos(spot.z + int'($urandom_range(0, 1536)) - 768);
            end
            else
            begin
                spot.x = rand_pos();
                spot.y = rand_pos();
                spot.z = rand_pos();
            end
            placed_spots.push_back(spot);
            add_item(OP_WRITE, spot.x, spot.y, spot.z, dx, dy, dz, $urandom_range(0, 255));
        end
        else if (pick < 85 && placed_spots.size() != 0)
        begin
            spot = placed_spots[$urandom_range(0, placed_spots.size() - 1)];
            if ($urandom_range(0, 1) == 1)
                k = $urandom_range(0, depth_cfg);
            else
                k = $urandom_range(0, (depth_cfg < 4) ? depth_cfg : 4);
            ox = spot.x - k * dx;
            oy = spot.y - k * dy;
            oz = spot.z - k * dz;
            while (k > 0 && !(pos_ok(ox) && pos_ok(oy) && pos_ok(oz)))
            begin
                k--;
                ox = spot.x - k * dx;
                oy = spot.y - k * dy;
                oz = spot.z - k * dz;
            end
            add_item(OP_SCAN, ox, oy, oz, dx, dy, dz, $urandom_range(0, 255));
        end
        else
            add_item(OP_SCAN, rand_pos(), rand_pos(), rand_pos(), dx, dy, dz,
                     $urandom_range(0, 255));
    endtask

    task automatic run_setting(input int depth_cfg, input int step_cfg, input int count,
                               input bit long_hold);
        wait_drained();
        write_reg(REG_MAX_DEPTH, CFG_DATA_W'(depth_cfg));
        write_reg(REG_SHADE_STEP, CFG_DATA_W'(step_cfg));
        setting_count++;
        if (long_hold)
            hold_requests++;
        repeat (count)
            push_random_item(depth_cfg);
    endtask

    initial
    begin
        int md;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Registers are taken during the clearing pass, and
        // the items wait until the store is ready.
        write_reg(REG_MAX_DEPTH, CFG_DATA_W'(4));
        write_reg(REG_SHADE_STEP, CFG_DATA_W'(19200));
        setting_count++;
        add_item(OP_SCAN, 0, 0, 0, 0, 0, 0, 0);                 // empty grid, miss
        add_item(OP_WRITE, POS_MIN, POS_MIN, POS_MIN, 0, 0, 0, 255);
        add_item(OP_WRITE, POS_MAX, POS_MAX, POS_MAX, 0, 0, 0, 0);
        add_item(OP_WRITE, 0, 0, 0, 0, 0, 0, 128);
        add_item(OP_SCAN, POS_MIN, POS_MIN, POS_MIN, 0, 0, 0, 0);   // hit at the origin
        add_item(OP_SCAN, POS_MAX, POS_MAX, POS_MAX, 256, 256, 256, 255);
        add_item(OP_SCAN, -8000, 0, 0, -256, 0, 0, 0);          // leaves the grid low
        add_item(OP_SCAN, POS_MAX, -256, 0, 256, 0, 0, 0);      // leaves the grid high
        add_item(OP_WRITE, 512, 1024, 0, 0, 0, 0, 10);
        add_item(OP_SCAN, 0, 1024, 0, 256, 0, 0, 0);            // loss exceeds the color
        add_item(OP_WRITE, 512, 2048, 0, 0, 0, 0, 255);
        add_item(OP_SCAN, 0, 2048, 0, 256, 0, 0, 0);            // dimmed hit
        add_item(OP_SCAN, 0, 2048, 0, 128, 0, 0, 0);            // half-cell steps
        add_item(OP_WRITE, 512, 2048, 0, 0, 0, 0, 77);          // overwrite
        add_item(OP_SCAN, 0, 2048, 0, 256, 0, 0, 0);
        add_item(OP_SCAN, 1024, 1024, 0, -256, 0, 0, 0);
        add_item(OP_WRITE, 0, 0, 1024, 0, 0, 0, 200);
        add_item(OP_SCAN, 0, 0, 1536, 0, 0, -256, 0);
        add_item(OP_SCAN, 0, -1536, 0, 0, 256, 0, 0);           // stops short, miss
        add_item(OP_SCAN, 100, -100, 50, -256, 256, -256, 255);
        add_item(OP_WRITE, -1, -1, -1, 0, 0, 0, 1);             // truncation below center
        add_item(OP_SCAN, -1, -1, -1, 0, 0, 0, 0);
        add_item(OP_SCAN, -257, 0, 0, 1, 0, 0, 0);

        // Random part over several settings, the extremes among them.
        run_setting(1, 76800, 150, 1'b0);
        run_setting(0, 76800, 100, 1'b0);
        run_setting(255, 300, 40, 1'b0);
        run_setting(16, 4800, 250, 1'b1);
        run_setting(8, 9600, 250, 1'b0);
        run_setting(255, 0, 40, 1'b0);
        run_setting(40, 1920, 200, 1'b0);
        run_setting(3, 25600, 200, 1'b0);
        repeat (3)
        begin
            md = $urandom_range(1, 48);
            run_setting(md, $urandom_range(0, 76800), 140, 1'b0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predicted_outcomes.size() != 0)
        begin
            $error("%0d results never arrived", predicted_outcomes.size());
            fail_count++;
        end
        $display("Covered %0d voxel writes and %0d scans (%0d hits, %0d misses).",
                 write_count, scan_count, hit_count, miss_count);
        $display("Register settings used: %0d, with one long output hold-off.",
                 setting_count);
        if (fail_count == 0)
            $display("voxel_grid_ray_march_test: clean");
        else
            $display("voxel_grid_ray_march_test: errors");
        $finish;
    end

    // Guard against a hang; allows for the clearing pass and the slowest scans.
    initial
    begin
        #16000000;
        $display("voxel_grid_ray_march_test: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/vgrm_pkg.sv
hw/rtl/voxel_grid_ray_march.sv
hw/rtl/vgrm_checker.sv
tb/voxel_grid_ray_march_test.sv
